// ----- rtl/itrs_pkg.sv -----
// Constants and the digit-to-ASCII mapping for the integer to text converter.
package itrs_pkg;

	localparam int VALUE_BITS = 32;
	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;
	localparam int DIGIT_W = 6;
	localparam int DIG_AW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
	localparam int BIT_CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

	localparam logic [BASE_W-1:0] RADIX_MIN = BASE_W'(2);
	localparam logic [BASE_W-1:0] RADIX_MAX = BASE_W'(36);
	localparam logic [DIGIT_W-1:0] DIGIT_LIMIT = DIGIT_W'(10);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(8'h30);
	localparam logic [CHAR_W-1:0] ASCII_A = CHAR_W'(8'h41);
	localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(8'h2D);

	// Digit values never exceed 35 here, so the letter range needs no wrap.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DIGIT_LIMIT) begin
			c = ASCII_ZERO + CHAR_W'(d);
		end else begin
			c = ASCII_A + CHAR_W'(d - DIGIT_LIMIT);
		end
		return c;
	endfunction

endpackage

// ----- rtl/int_to_radix_string.sv -----
// Signed integer to ASCII text in radix 2 to 36, one character per strobe.
//
//   Channel   Handshake         Payload
//   request   start / busy      value, base
//   result    strobe            character, last
//
// A request is taken when start is high and busy is low.
// Each digit comes from a restoring division by the radix, one quotient bit per
// cycle; digits go to a small digit store. Readout passes each character through
// the store read and then the output register.
// Reset clears the control state; the digit store is not cleared.
// The receiver cannot stall: each character is shown for one cycle.
module int_to_radix_string
	import itrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [BASE_W-1:0]     base,
	output logic                  strobe,
	output logic [CHAR_W-1:0]     character,
	output logic                  last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [VALUE_BITS-1:0] quo_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BASE_W-1:0]     radix_q;
	logic                  nz_q;
	logic [BIT_CW-1:0]     bit_q;
	logic [DIG_AW-1:0]     ptr_q;
	logic                  strobe_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	logic [DIGIT_W-1:0]    dig_mem [VALUE_BITS];
	logic [DIGIT_W-1:0]    rd_q;

	logic                  accept;
	logic [VALUE_BITS-1:0] mag;
	logic [BASE_W-1:0]     radix_in;
	logic [DIGIT_W:0]      rem_sh;
	logic                  ge;
	logic [DIGIT_W:0]      rem_nx;
	logic                  digit_done;

	assign accept = start && (state_q == ST_IDLE);
	assign mag = value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;

	always_comb begin
		priority if (base < RADIX_MIN) begin
			radix_in = RADIX_MIN;
		end else if (base > RADIX_MAX) begin
			radix_in = RADIX_MAX;
		end else begin
			radix_in = base;
		end
	end

	// One step of restoring division: bring in the next dividend bit.
	assign rem_sh = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge = rem_sh >= {1'b0, radix_q};
	assign rem_nx = ge ? (rem_sh - {1'b0, radix_q}) : rem_sh;
	assign digit_done = (state_q == ST_DIV) && (bit_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			nz_q     <= 1'b0;
			bit_q    <= '0;
			ptr_q    <= '0;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						quo_q   <= mag;
						rem_q   <= '0;
						radix_q <= radix_in;
						nz_q    <= 1'b0;
						bit_q   <= BIT_CW'(VALUE_BITS - 1);
						ptr_q   <= '0;
						// The sign goes out as soon as the request is taken.
						if (value[VALUE_BITS-1]) begin
							strobe_q <= 1'b1;
							char_q   <= ASCII_MINUS;
							last_q   <= 1'b0;
						end
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quo_q <= {quo_q[VALUE_BITS-2:0], ge};
					if (bit_q != '0) begin
						rem_q <= rem_nx[DIGIT_W-1:0];
						nz_q  <= nz_q | ge;
						bit_q <= bit_q - BIT_CW'(1);
					end else if (nz_q || ge) begin
						// The quotient is the dividend for the next digit.
						rem_q <= '0;
						nz_q  <= 1'b0;
						bit_q <= BIT_CW'(VALUE_BITS - 1);
						ptr_q <= ptr_q + DIG_AW'(1);
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					char_q   <= digit_char(rd_q);
					last_q   <= (ptr_q == '0);
					if (ptr_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						ptr_q   <= ptr_q - DIG_AW'(1);
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Digit store: least significant digit at index zero, read back downward.
	always_ff @(posedge clk) begin
		if (digit_done) begin
			dig_mem[ptr_q] <= rem_nx[DIGIT_W-1:0];
		end
		rd_q <= dig_mem[ptr_q];
	end

	assign busy = (state_q != ST_IDLE);
	assign strobe = strobe_q;
	assign character = char_q;
	assign last = last_q;

	// The running remainder always stays below the radix.
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> ({1'b0, rem_q} < {1'b0, radix_q}))
		else $error("remainder out of range");

	// A request is never taken while one is in progress, and takes the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request taken without going busy");

	// Right after the final character only the sign of a newly taken request can follow.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |=> (!strobe || (character == ASCII_MINUS)))
		else $error("character right after the final one");

	// Digits are shown only from the readout states; the check covers the final character.
	a_emit_src: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && last) |-> ($past(state_q) == ST_EMIT))
		else $error("final character not from readout");

endmodule
